// File: src/ljpf_pkg.sv
// ----------------------------------------------------------------------------
// ljpf_pkg: shared types and constants for the Lennard-Jones pair force unit
// Widths, sideband struct and output saturation helper.
// ----------------------------------------------------------------------------
package ljpf_pkg;

    localparam int DW   = 24;   // displacement width
    localparam int SW   = 48;   // r^2 width
    localparam int QW   = 45;   // r^-2 width, one quotient bit per divider stage
    localparam int MW   = 58;   // multiplier operand width
    localparam int MH   = 29;   // multiplier split point
    localparam int PW   = 116;  // multiplier product width
    localparam int TAIL = 14;   // stages after the divider, before the output register

    localparam logic [SW-1:0] REM_INIT  = 48'h0001_0000_0000;
    localparam logic [SW-1:0] SMALL_LIM = 48'h0001_0000_0000;
    localparam logic [53:0]   T_ONE     = 54'd1 << 41;
    localparam logic [31:0]   POS_LIM   = 32'h7FFF_FFFF;
    localparam logic [31:0]   NEG_LIM   = 32'h8000_0000;

    typedef struct packed {
        logic                 near;
        logic [2:0]           dneg;
        logic [2:0][DW-1:0]   mag;
        logic                 tneg;
        logic [31:0]          energy;
        logic                 esat;
    } side_t;

    typedef struct packed {
        logic [31:0] val;
        logic        sat;
    } sat_t;

    function automatic sat_t sat32(input logic [54:0] m, input logic neg);
        sat_t r;
        r.sat = |m[54:31];
        if (neg)
            r.val = r.sat ? NEG_LIM : (32'd0 - m[31:0]);
        else
            r.val = r.sat ? POS_LIM : m[31:0];
        return r;
    endfunction

endpackage

// File: src/ljpf_ifs.sv
// ----------------------------------------------------------------------------
// ljpf channel interfaces
// Valid/ready channels for displacement requests and force results.
// ----------------------------------------------------------------------------
interface ljpf_in_if;
    logic               valid;
    logic               ready;
    logic signed [23:0] disp_x;
    logic signed [23:0] disp_y;
    logic signed [23:0] disp_z;

    modport source (output valid, disp_x, disp_y, disp_z, input ready);
    modport sink   (input valid, disp_x, disp_y, disp_z, output ready);
endinterface

interface ljpf_out_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] energy;
    logic signed [31:0] force_x;
    logic signed [31:0] force_y;
    logic signed [31:0] force_z;
    logic               saturated;

    modport source (output valid, energy, force_x, force_y, force_z, saturated,
                    input ready);
    modport sink   (input valid, energy, force_x, force_y, force_z, saturated,
                    output ready);
endinterface

// File: src/lennard_jones_pair_force.sv
// ----------------------------------------------------------------------------
// lennard_jones_pair_force: 12-6 Lennard-Jones energy and force per pair
//
// pair   : valid/ready sink; one transaction carries a displacement
//          (second minus first particle), three signed Q5.18 components.
// result : valid/ready source; energy and force on the first particle in
//          signed Q15.16, saturated, plus a flag for a too-small distance
//          or any clipped field.
// One result per transaction, in order. From accept to result valid a pair
// passes the 45-stage reciprocal divider and four three-stage multiplier
// ranks. A new transaction is taken every cycle unless the receiver stalls.
// When the receiver stalls with a result waiting, the whole pipeline holds
// and pair.ready drops in the same cycle; nothing is lost or repeated.
// Reset clears all valid bits; the block is ready right after reset.
// ----------------------------------------------------------------------------
module lennard_jones_pair_force
    import ljpf_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    ljpf_in_if.sink     pair,
    ljpf_out_if.source  result
);

    logic                en;
    logic [2:0]          vh_reg;
    logic [TAIL-1:0]     vt_reg;
    logic                out_valid_reg;

    side_t               side_in;
    side_t               side1_reg, side2_reg, side3_reg;
    side_t               side3_next;
    logic [2*DW-1:0]     sq2_reg [3];
    logic [SW-1:0]       s_next;
    logic [SW-1:0]       s3_reg;
    logic [DW-1:0]       raw [3];

    logic                v_div;
    logic [QW-1:0]       inv2;
    side_t               side_div;

    side_t               st_reg [TAIL];
    side_t               st_next [TAIL];
    logic [QW-1:0]       inv2d_reg [3];
    logic [52:0]         s6d_reg [3];

    logic [PW-1:0]       m1_p, m2_p, m3_p, m4_p, m5_p;
    logic [PW-1:0]       mf_p [3];
    logic [48:0]         s4;
    logic [52:0]         s6;
    logic [56:0]         s8;
    logic [59:0]         s12;
    logic [52:0]         base;

    logic                tneg_t;
    logic [53:0]         ts, tmag_t;
    logic [52:0]         s6t_reg;
    logic [56:0]         s8t_reg;
    logic [53:0]         tmagt_reg;

    logic [60:0]         diff;
    logic [62:0]         em, emag;
    sat_t                esat;
    logic [MW-1:0]       vm_next, vm_reg;

    sat_t                fs [3];
    logic [31:0]         fval [3];
    logic [31:0]         energy_reg;
    logic [2:0][31:0]    force_reg;
    logic                sat_reg;
    side_t               fin;

    assign en         = !out_valid_reg || result.ready;
    assign pair.ready = en;

    // stage 1: magnitudes and signs
    assign raw[0] = pair.disp_x;
    assign raw[1] = pair.disp_y;
    assign raw[2] = pair.disp_z;

    always_comb
    begin
        side_in = '0;
        for (int i = 0; i < 3; i++)
        begin
            side_in.dneg[i] = raw[i][DW-1];
            side_in.mag[i]  = raw[i][DW-1] ? (DW'(0) - raw[i]) : raw[i];
        end
    end

    assign s_next = SW'({2'b0, sq2_reg[0]}) + SW'({2'b0, sq2_reg[1]})
                  + SW'({2'b0, sq2_reg[2]});

    always_comb
    begin
        side3_next      = side2_reg;
        side3_next.near = (s_next <= SMALL_LIM);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vh_reg        <= '0;
            vt_reg        <= '0;
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            vh_reg        <= {vh_reg[1:0], pair.valid};
            vt_reg        <= {vt_reg[TAIL-2:0], v_div};
            out_valid_reg <= vt_reg[TAIL-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            side1_reg <= side_in;
            for (int i = 0; i < 3; i++)
                sq2_reg[i] <= side1_reg.mag[i] * side1_reg.mag[i];
            side2_reg <= side1_reg;
            s3_reg    <= s_next;
            side3_reg <= side3_next;
        end
    end

    ljpf_recip u_recip (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (vh_reg[2]),
        .in_s      (s3_reg),
        .in_side   (side3_reg),
        .out_valid (v_div),
        .out_q     (inv2),
        .out_side  (side_div)
    );

    // r^-4, then r^-6 and r^-8
    ljpf_mul u_m1 (.clk(clk), .en(en), .a(MW'(inv2)), .b(MW'(inv2)), .p(m1_p));
    assign s4 = m1_p[89:41];

    ljpf_mul u_m2 (.clk(clk), .en(en), .a(MW'(s4)), .b(MW'(inv2d_reg[2])), .p(m2_p));
    ljpf_mul u_m3 (.clk(clk), .en(en), .a(MW'(s4)), .b(MW'(s4)), .p(m3_p));
    assign s6 = m2_p[93:41];
    assign s8 = m3_p[97:41];

    // (2 r^-6 - 1) as sign and magnitude
    assign tneg_t = (s6[52:40] == '0);
    assign ts     = {s6, 1'b0};
    assign tmag_t = tneg_t ? (T_ONE - ts) : (ts - T_ONE);

    ljpf_mul u_m4 (.clk(clk), .en(en), .a(MW'(s6t_reg)), .b(MW'(s6t_reg)), .p(m4_p));
    ljpf_mul u_m5 (.clk(clk), .en(en), .a(MW'(s8t_reg)), .b(MW'(tmagt_reg)), .p(m5_p));
    assign s12  = m4_p[105:46];
    assign base = m5_p[110:58];

    // energy and force scale
    assign diff    = {1'b0, s12} - {13'b0, s6d_reg[2][52:5]};
    assign em      = {diff, 2'b00};
    assign emag    = em[62] ? (63'd0 - em) : em;
    assign esat    = sat32({12'b0, emag[62:20]}, em[62]);
    assign vm_next = {1'b0, base, 4'b0} + {2'b0, base, 3'b0};

    always_comb
    begin
        for (int k = 0; k < TAIL; k++)
            st_next[k] = (k == 0) ? side_div : st_reg[k-1];
        st_next[6].tneg    = tneg_t;
        st_next[10].energy = esat.val;
        st_next[10].esat   = esat.sat;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int k = 0; k < TAIL; k++)
                st_reg[k] <= st_next[k];
            inv2d_reg[0] <= inv2;
            s6d_reg[0]   <= s6t_reg;
            for (int k = 1; k < 3; k++)
            begin
                inv2d_reg[k] <= inv2d_reg[k-1];
                s6d_reg[k]   <= s6d_reg[k-1];
            end
            s6t_reg   <= s6;
            s8t_reg   <= s8;
            tmagt_reg <= tmag_t;
            vm_reg    <= vm_next;
        end
    end

    genvar g;
    generate
        for (g = 0; g < 3; g++)
        begin : g_force
            ljpf_mul u_mf (
                .clk (clk),
                .en  (en),
                .a   (MW'(st_reg[10].mag[g])),
                .b   (vm_reg),
                .p   (mf_p[g])
            );
        end
    endgenerate

    // output stage
    assign fin = st_reg[TAIL-1];

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            fs[i] = sat32(mf_p[i][80:26], fin.dneg[i] == fin.tneg);
            if (fin.dneg[i])
                fval[i] = POS_LIM;
            else if (fin.mag[i] != '0)
                fval[i] = NEG_LIM;
            else
                fval[i] = '0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            if (fin.near)
            begin
                energy_reg <= POS_LIM;
                for (int i = 0; i < 3; i++)
                    force_reg[i] <= fval[i];
                sat_reg <= 1'b1;
            end
            else
            begin
                energy_reg <= fin.energy;
                for (int i = 0; i < 3; i++)
                    force_reg[i] <= fs[i].val;
                sat_reg <= fin.esat | fs[0].sat | fs[1].sat | fs[2].sat;
            end
        end
    end

    assign result.valid     = out_valid_reg;
    assign result.energy    = energy_reg;
    assign result.force_x   = force_reg[0];
    assign result.force_y   = force_reg[1];
    assign result.force_z   = force_reg[2];
    assign result.saturated = sat_reg;

    a_near_sat : assert property (@(posedge clk) disable iff (!rst_n)
        en && vt_reg[TAIL-1] && fin.near
        |=> result.valid && result.saturated && result.energy == POS_LIM)
        else $error("too-small distance not reported as saturated");

    a_stall_hold : assert property (@(posedge clk) disable iff (!rst_n)
        !en |=> $stable(vt_reg) && $stable(vh_reg))
        else $error("pipeline moved during stall");

endmodule

// File: src/ljpf_mul.sv
// ----------------------------------------------------------------------------
// ljpf_mul: three-stage 58x58 unsigned multiplier
// Four 29x29 partial products, then two registered adds.
// ----------------------------------------------------------------------------
module ljpf_mul
    import ljpf_pkg::*;
(
    input  logic          clk,
    input  logic          en,
    input  logic [MW-1:0] a,
    input  logic [MW-1:0] b,
    output logic [PW-1:0] p
);

    logic [2*MH-1:0] pp00_reg, pp01_reg, pp10_reg, pp11_reg;
    logic [2*MH:0]   mid_reg;
    logic [PW-1:0]   cat_reg;
    logic [PW-1:0]   p_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            pp00_reg <= a[MH-1:0]  * b[MH-1:0];
            pp01_reg <= a[MH-1:0]  * b[MW-1:MH];
            pp10_reg <= a[MW-1:MH] * b[MH-1:0];
            pp11_reg <= a[MW-1:MH] * b[MW-1:MH];
            mid_reg  <= {1'b0, pp01_reg} + {1'b0, pp10_reg};
            cat_reg  <= {pp11_reg, pp00_reg};
            p_reg    <= cat_reg + {{(PW-2*MH-1-MH){1'b0}}, mid_reg, {MH{1'b0}}};
        end
    end

    assign p = p_reg;

endmodule

// File: src/ljpf_recip.sv
// ----------------------------------------------------------------------------
// ljpf_recip: pipelined restoring divider for floor(2^77 / r^2)
// One quotient bit per stage, sideband carried alongside.
// ----------------------------------------------------------------------------
module ljpf_recip
    import ljpf_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          en,
    input  logic          in_valid,
    input  logic [SW-1:0] in_s,
    input  side_t         in_side,
    output logic          out_valid,
    output logic [QW-1:0] out_q,
    output side_t         out_side
);

    logic [QW-1:0] v_reg, v_next;
    logic [SW-1:0] rem_reg [QW];
    logic [SW-1:0] rem_next [QW];
    logic [SW-1:0] s_reg [QW];
    logic [SW-1:0] s_next [QW];
    logic [QW-1:0] q_reg [QW];
    logic [QW-1:0] q_next [QW];
    side_t         side_reg [QW];
    side_t         side_next [QW];
    logic [SW-1:0] rin [QW];
    logic [QW-1:0] qin [QW];
    logic [SW:0]   r2 [QW];

    always_comb
    begin
        for (int j = 0; j < QW; j++)
        begin
            if (j == 0)
            begin
                rin[j]       = REM_INIT;
                qin[j]       = '0;
                s_next[j]    = in_s;
                side_next[j] = in_side;
                v_next[j]    = in_valid;
            end
            else
            begin
                rin[j]       = rem_reg[j-1];
                qin[j]       = q_reg[j-1];
                s_next[j]    = s_reg[j-1];
                side_next[j] = side_reg[j-1];
                v_next[j]    = v_reg[j-1];
            end
            r2[j] = {rin[j], 1'b0};
            if (r2[j] >= {1'b0, s_next[j]})
            begin
                rem_next[j] = SW'(r2[j] - {1'b0, s_next[j]});
                q_next[j]   = {qin[j][QW-2:0], 1'b1};
            end
            else
            begin
                rem_next[j] = r2[j][SW-1:0];
                q_next[j]   = {qin[j][QW-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg <= '0;
        else if (en)
            v_reg <= v_next;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int j = 0; j < QW; j++)
            begin
                rem_reg[j]  <= rem_next[j];
                s_reg[j]    <= s_next[j];
                q_reg[j]    <= q_next[j];
                side_reg[j] <= side_next[j];
            end
        end
    end

    assign out_valid = v_reg[QW-1];
    assign out_q     = q_reg[QW-1];
    assign out_side  = side_reg[QW-1];

endmodule
